FILE: rtl/hlt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hlt_pkg: shared types and constants of the heartbeat liveness table
// Table sizing, operation, result and status codes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package hlt_pkg;

    // table sizing
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int ID_W     = 8;
    localparam int MISS_W   = 8;
    localparam int LIMIT_W  = 8;
    localparam int OP_W     = 2;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int TALLY_W  = 5;
    localparam int ENTRY_W  = ID_W + MISS_W;

    // stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;
    localparam int M_USED_W  = ID_W + STATUS_W + 1 + TALLY_W + TALLY_W;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOVAL_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARNING_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MODULE_ID = 2'd2;

    localparam logic [LIMIT_W-1:0] RESET_REMOVAL_LIMIT = 8'd3;
    localparam logic [LIMIT_W-1:0] RESET_WARNING_LIMIT = 8'd2;
    localparam logic [ID_W-1:0]    RESET_MAX_MODULE_ID = 8'd16;

    // input operations
    localparam logic [OP_W-1:0] OP_HEARTBEAT = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK      = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE    = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_HB      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_REFRESHED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;

    // table read address select
    localparam logic RD_IDX  = 1'b0;
    localparam logic RD_LAST = 1'b1;

    // table write select
    localparam logic [1:0] WR_APPEND  = 2'd0;
    localparam logic [1:0] WR_REFRESH = 2'd1;
    localparam logic [1:0] WR_MOVE    = 2'd2;
    localparam logic [1:0] WR_KEEP    = 2'd3;

    // result id select
    localparam logic [1:0] RID_ZERO = 2'd0;
    localparam logic [1:0] RID_KEY  = 2'd1;
    localparam logic [1:0] RID_RD   = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic                in_load;
        logic                idx_clr;
        logic                idx_inc;
        logic                warn_clr;
        logic                warn_inc;
        logic                rd_en;
        logic                rd_sel;
        logic                wr_en;
        logic [1:0]          wr_sel;
        logic                total_inc;
        logic                total_dec;
        logic                res_set;
        logic [KIND_W-1:0]   res_kind;
        logic [STATUS_W-1:0] res_status;
        logic [1:0]          res_id_sel;
        logic                res_last;
        logic                out_load;
    } hlt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            idx_end;
        logic            full;
        logic            match;
        logic            expire;
        logic            warn_hit;
        logic            out_free;
    } hlt_stat_t;

endpackage
`default_nettype wire

FILE: rtl/hlt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hlt_ram: generic single-clock ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hlt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: rtl/hlt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hlt_ctrl: sequencer of the heartbeat liveness table
// Walks the table one entry at a time for search and tick, and hands
// each result to the output register.
// ----------------------------------------------------------------------------
module hlt_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire hlt_pkg::hlt_stat_t st,
    output hlt_pkg::hlt_cmd_t       cmd
);
    import hlt_pkg::*;

    localparam int SW = 4;
    localparam logic [SW-1:0] S_IDLE     = 4'd0;
    localparam logic [SW-1:0] S_START    = 4'd1;
    localparam logic [SW-1:0] S_SRD      = 4'd2;
    localparam logic [SW-1:0] S_SCMP     = 4'd3;
    localparam logic [SW-1:0] S_RLAST    = 4'd4;
    localparam logic [SW-1:0] S_RMOVE    = 4'd5;
    localparam logic [SW-1:0] S_TRD      = 4'd6;
    localparam logic [SW-1:0] S_TUPD     = 4'd7;
    localparam logic [SW-1:0] S_TMOVE_RD = 4'd8;
    localparam logic [SW-1:0] S_TMOVE_WR = 4'd9;
    localparam logic [SW-1:0] S_EMIT     = 4'd10;

    logic [SW-1:0] state_reg, state_next;
    logic [SW-1:0] ret_reg, ret_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.in_load = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START: begin
                cmd.idx_clr  = 1'b1;
                cmd.warn_clr = 1'b1;
                priority if (st.op == OP_HEARTBEAT || st.op == OP_REMOVE) begin
                    state_next = S_SRD;
                end else if (st.op == OP_TICK) begin
                    state_next = S_TRD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            // search: issue the read of the current slot or conclude absent
            S_SRD: begin
                if (st.idx_end) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_id_sel = RID_KEY;
                    cmd.res_last   = 1'b1;
                    state_next     = S_EMIT;
                    ret_next       = S_IDLE;
                    priority if (st.op == OP_REMOVE) begin
                        cmd.res_kind   = KIND_REMOVE;
                        cmd.res_status = ST_NOT_FOUND;
                    end else if (st.full) begin
                        cmd.res_kind   = KIND_HB;
                        cmd.res_status = ST_FULL;
                    end else begin
                        cmd.wr_en      = 1'b1;
                        cmd.wr_sel     = WR_APPEND;
                        cmd.total_inc  = 1'b1;
                        cmd.res_kind   = KIND_HB;
                        cmd.res_status = ST_ADDED;
                    end
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX;
                    state_next = S_SCMP;
                end
            end
            // search: compare the slot read back
            S_SCMP: begin
                priority if (!st.match) begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SRD;
                end else if (st.op == OP_REMOVE) begin
                    cmd.total_dec = 1'b1;
                    state_next    = S_RLAST;
                end else begin
                    cmd.wr_en      = 1'b1;
                    cmd.wr_sel     = WR_REFRESH;
                    cmd.res_set    = 1'b1;
                    cmd.res_kind   = KIND_HB;
                    cmd.res_status = ST_REFRESHED;
                    cmd.res_id_sel = RID_KEY;
                    cmd.res_last   = 1'b1;
                    state_next     = S_EMIT;
                    ret_next       = S_IDLE;
                end
            end
            // remove: fetch the last entry, then move it into the hole
            S_RLAST: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_LAST;
                state_next = S_RMOVE;
            end
            S_RMOVE: begin
                cmd.wr_en      = 1'b1;
                cmd.wr_sel     = WR_MOVE;
                cmd.res_set    = 1'b1;
                cmd.res_kind   = KIND_REMOVE;
                cmd.res_status = ST_REMOVED;
                cmd.res_id_sel = RID_KEY;
                cmd.res_last   = 1'b1;
                state_next     = S_EMIT;
                ret_next       = S_IDLE;
            end
            // tick: read the next entry or give the summary
            S_TRD: begin
                if (st.idx_end) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_kind   = KIND_SUMMARY;
                    cmd.res_status = ST_REFRESHED;
                    cmd.res_id_sel = RID_ZERO;
                    cmd.res_last   = 1'b1;
                    state_next     = S_EMIT;
                    ret_next       = S_IDLE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX;
                    state_next = S_TUPD;
                end
            end
            // tick: age the entry, keep it or expire it
            S_TUPD: begin
                if (st.expire) begin
                    cmd.total_dec  = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_kind   = KIND_EXPIRED;
                    cmd.res_status = ST_REMOVED;
                    cmd.res_id_sel = RID_RD;
                    state_next     = S_EMIT;
                    ret_next       = S_TMOVE_RD;
                end else begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_sel   = WR_KEEP;
                    cmd.warn_inc = st.warn_hit;
                    cmd.idx_inc  = 1'b1;
                    state_next   = S_TRD;
                end
            end
            // tick: refill the freed slot from the end, not yet visited
            S_TMOVE_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_LAST;
                state_next = S_TMOVE_WR;
            end
            S_TMOVE_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_MOVE;
                state_next = S_TRD;
            end
            S_EMIT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ret_reg;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // assertions
    a_load_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.in_load |=> (state_reg == S_START))
        else $error("item taken outside idle");

    a_emit_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) && st.out_free |=> (state_reg == $past(ret_reg)))
        else $error("emit did not return to saved state");

    a_no_write_on_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> !cmd.wr_en && !cmd.rd_en)
        else $error("table access while emitting");

endmodule
`default_nettype wire

FILE: rtl/hlt_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hlt_datapath: table, counters and result register
// Holds the entry table ram, entry count, walk index, warning tally,
// configuration registers and the output beat register.
// ----------------------------------------------------------------------------
module hlt_datapath (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire hlt_pkg::hlt_cmd_t                    cmd,
    output hlt_pkg::hlt_stat_t                        st,
    input  wire logic [hlt_pkg::S_TDATA_W-1:0]        s_tdata,
    input  wire logic [hlt_pkg::OP_W-1:0]             s_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic      [hlt_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic      [hlt_pkg::KIND_W-1:0]           m_tuser,
    output logic                                      m_tlast,
    input  wire logic                                 cfg_we,
    input  wire logic [hlt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [hlt_pkg::LIMIT_W-1:0]          cfg_wdata
);
    import hlt_pkg::*;

    logic [OP_W-1:0]     op_reg;
    logic [ID_W-1:0]     key_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    total_reg;
    logic [CNT_W-1:0]    warn_reg;
    logic [LIMIT_W-1:0]  removal_limit_reg;
    logic [LIMIT_W-1:0]  warning_limit_reg;
    logic [ID_W-1:0]     max_id_reg;

    logic [KIND_W-1:0]   res_kind_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [ID_W-1:0]     res_id_reg;
    logic                res_reply_reg;
    logic                res_last_reg;
    logic [ID_W-1:0]     res_id_next;

    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [KIND_W-1:0]   m_tuser_reg;
    logic                m_tlast_reg;

    logic [ENTRY_W-1:0]  rd_entry;
    logic [ID_W-1:0]     rd_id;
    logic [MISS_W-1:0]   rd_miss;
    logic [MISS_W-1:0]   aged_miss;
    logic [IDX_W-1:0]    ram_raddr;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [TALLY_W-1:0]  warn_field;

    // entry table: count in the upper byte, id in the lower
    hlt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (ram_raddr),
        .rdata (rd_entry)
    );

    assign rd_id     = rd_entry[ID_W-1:0];
    assign rd_miss   = rd_entry[ENTRY_W-1:ID_W];
    assign aged_miss = (rd_miss == {MISS_W{1'b1}}) ? rd_miss : rd_miss + MISS_W'(1);

    // table addressing; the last slot is read after the count drops
    assign ram_raddr = (cmd.rd_sel == RD_LAST) ? total_reg[IDX_W-1:0] : idx_reg[IDX_W-1:0];

    always_comb begin
        unique case (cmd.wr_sel)
            WR_APPEND: begin
                ram_waddr = total_reg[IDX_W-1:0];
                ram_wdata = {{MISS_W{1'b0}}, key_reg};
            end
            WR_REFRESH: begin
                ram_waddr = idx_reg[IDX_W-1:0];
                ram_wdata = {{MISS_W{1'b0}}, key_reg};
            end
            WR_MOVE: begin
                ram_waddr = idx_reg[IDX_W-1:0];
                ram_wdata = rd_entry;
            end
            WR_KEEP: begin
                ram_waddr = idx_reg[IDX_W-1:0];
                ram_wdata = {aged_miss, rd_id};
            end
            default: begin
                ram_waddr = idx_reg[IDX_W-1:0];
                ram_wdata = rd_entry;
            end
        endcase
    end

    // status toward the controller
    assign st.op       = op_reg;
    assign st.idx_end  = (idx_reg >= total_reg);
    assign st.full     = (total_reg >= CNT_W'(TABLE_DEPTH));
    assign st.match    = (rd_id == key_reg);
    assign st.expire   = (aged_miss > removal_limit_reg);
    assign st.warn_hit = (aged_miss > warning_limit_reg);
    assign st.out_free = !m_tvalid_reg || m_tready;

    // control counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            total_reg <= '0;
            warn_reg  <= '0;
        end else begin
            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (cmd.total_inc) begin
                total_reg <= total_reg + CNT_W'(1);
            end else if (cmd.total_dec) begin
                total_reg <= total_reg - CNT_W'(1);
            end
            if (cmd.warn_clr) begin
                warn_reg <= '0;
            end else if (cmd.warn_inc) begin
                warn_reg <= warn_reg + CNT_W'(1);
            end
        end
    end

    // input beat capture
    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            op_reg  <= s_tuser;
            key_reg <= s_tdata[ID_W-1:0];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            removal_limit_reg <= RESET_REMOVAL_LIMIT;
            warning_limit_reg <= RESET_WARNING_LIMIT;
            max_id_reg        <= RESET_MAX_MODULE_ID;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_REMOVAL_LIMIT: removal_limit_reg <= cfg_wdata;
                CFG_WARNING_LIMIT: warning_limit_reg <= cfg_wdata;
                CFG_MAX_MODULE_ID: max_id_reg        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // result staging
    always_comb begin
        unique case (cmd.res_id_sel)
            RID_KEY: res_id_next = key_reg;
            RID_RD:  res_id_next = rd_id;
            default: res_id_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_set) begin
            res_kind_reg   <= cmd.res_kind;
            res_status_reg <= cmd.res_status;
            res_id_reg     <= res_id_next;
            res_reply_reg  <= (cmd.res_kind == KIND_HB) && (key_reg <= max_id_reg);
            res_last_reg   <= cmd.res_last;
        end
    end

    // output beat register
    assign warn_field = (res_kind_reg == KIND_SUMMARY) ? TALLY_W'(warn_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {{(M_TDATA_W - M_USED_W){1'b0}}, warn_field,
                            TALLY_W'(total_reg), res_reply_reg, res_status_reg,
                            res_id_reg};
            m_tuser_reg <= res_kind_reg;
            m_tlast_reg <= res_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // assertions
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_no_append_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.total_inc |-> !st.full)
        else $error("append into a full table");

    a_no_drop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.total_dec |-> (total_reg != '0) && (idx_reg < total_reg))
        else $error("drop outside the occupied slots");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> st.out_free)
        else $error("output beat overwritten");

endmodule
`default_nettype wire

FILE: rtl/heartbeat_liveness_table_unit.sv
`default_nettype none
// The unit takes one item at a time: a new input beat is accepted only in idle,
// once the previous item is through and any last result of it has been loaded
// into the output register. The entry table ram has a registered read, so each
// entry is read in a read state before it is compared, aged or moved.
// Reset clears the entry count, the handshakes and restores the limits to their
// defaults; table contents are not cleared, no clearing pass is run.
// ----------------------------------------------------------------------------
// heartbeat_liveness_table_unit: liveness table of heartbeat modules
// Refreshes, appends and removes module ids, ages all entries on a tick,
// reports expired ones and gives a warning summary.
// ----------------------------------------------------------------------------
module heartbeat_liveness_table_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input beats
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [hlt_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] module_id
    input  wire logic [hlt_pkg::OP_W-1:0]          s_tuser,   // [1:0] op
    // result beats
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [hlt_pkg::M_TDATA_W-1:0]     m_tdata,   // [7:0] module_id_res,
                                                              // [10:8] status,
                                                              // [11] reply_allowed,
                                                              // [16:12] active_count,
                                                              // [21:17] warn_count
    output logic      [hlt_pkg::KIND_W-1:0]        m_tuser,   // [1:0] kind
    output logic                                   m_tlast,
    // configuration writes
    input  wire logic                              cfg_we,
    input  wire logic [hlt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [hlt_pkg::LIMIT_W-1:0]       cfg_wdata
);
    import hlt_pkg::*;

    hlt_cmd_t  cmd;
    hlt_stat_t st;

    // sequencer
    hlt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // table and result datapath
    hlt_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: testbench of the heartbeat liveness table unit
// Drives heartbeat, tick, remove and unused beats and predicts the table,
// its ageing and the results of every beat. Each result beat is checked
// field by field against the oldest prediction. Limits are rewritten between
// phases, unit idle. Both streams idle in random bursts, save in the last test.
// ----------------------------------------------------------------------------
module tb_top;
    import hlt_pkg::*;

    localparam int                CLK_HALF     = 5;
    localparam int                DRAIN_CYCLES = 100;
    localparam int                CYCLE_LIMIT  = 1000000;
    localparam int                POOL_SIZE    = 24;
    localparam logic [OP_W-1:0]   OP_UNUSED    = 2'd3;

    // one predicted result beat
    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [ID_W-1:0]     id;
        logic [STATUS_W-1:0] status;
        logic                reply;
        logic [TALLY_W-1:0]  active;
        logic [TALLY_W-1:0]  warn;
        logic                last;
    } answer_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = OP_HEARTBEAT;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_REMOVAL_LIMIT;
    logic [LIMIT_W-1:0]    cfg_wdata = '0;

    // predicted table contents and limits
    logic [ID_W-1:0]    tbl_id   [TABLE_DEPTH];
    logic [MISS_W-1:0]  tbl_miss [TABLE_DEPTH];
    int                 tbl_count;
    logic [LIMIT_W-1:0] lim_remove;
    logic [LIMIT_W-1:0] lim_warn;
    logic [ID_W-1:0]    lim_max_id;

    answer_t     pending_answers[$];
    logic [ID_W-1:0] id_pool[POOL_SIZE];
    int          errors = 0;
    int          cycles = 0;
    bit          calm   = 1'b0;

    heartbeat_liveness_table_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ---------------- table predictor ----------------

    function automatic void push_answer(input logic [KIND_W-1:0] kind,
                                        input logic [ID_W-1:0] id,
                                        input logic [STATUS_W-1:0] status,
                                        input logic reply, input int active,
                                        input int warn, input logic last);
        answer_t a;
        a.kind   = kind;
        a.id     = id;
        a.status = status;
        a.reply  = reply;
        a.active = active[TALLY_W-1:0];
        a.warn   = warn[TALLY_W-1:0];
        a.last   = last;
        pending_answers.push_back(a);
    endfunction

    function automatic int find_entry(input logic [ID_W-1:0] id);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_id[i] == id) return i;
        end
        return -1;
    endfunction

    // last entry moves into the freed slot
    function automatic void drop_entry(input int slot);
        tbl_count--;
        tbl_id[slot]   = tbl_id[tbl_count];
        tbl_miss[slot] = tbl_miss[tbl_count];
    endfunction

    function automatic void predict_table_op(input logic [OP_W-1:0] op,
                                             input logic [ID_W-1:0] id);
        int              slot;
        int              i;
        int              warn;
        logic            reply;
        logic [ID_W-1:0] gone;
        case (op)
            OP_HEARTBEAT: begin
                reply = (id <= lim_max_id);
                slot  = find_entry(id);
                if (slot >= 0) begin
                    tbl_miss[slot] = '0;
                    push_answer(KIND_HB, id, ST_REFRESHED, reply, tbl_count, 0, 1'b1);
                end else if (tbl_count >= TABLE_DEPTH) begin
                    push_answer(KIND_HB, id, ST_FULL, reply, tbl_count, 0, 1'b1);
                end else begin
                    tbl_id[tbl_count]   = id;
                    tbl_miss[tbl_count] = '0;
                    tbl_count++;
                    push_answer(KIND_HB, id, ST_ADDED, reply, tbl_count, 0, 1'b1);
                end
            end
            OP_REMOVE: begin
                slot = find_entry(id);
                if (slot >= 0) begin
                    drop_entry(slot);
                    push_answer(KIND_REMOVE, id, ST_REMOVED, 1'b0, tbl_count, 0, 1'b1);
                end else begin
                    push_answer(KIND_REMOVE, id, ST_NOT_FOUND, 1'b0, tbl_count, 0, 1'b1);
                end
            end
            OP_TICK: begin
                // age every entry once; a swapped-in entry is visited in place
                i = 0;
                while (i < tbl_count) begin
                    if (tbl_miss[i] != 8'hFF) tbl_miss[i] = tbl_miss[i] + 1'b1;
                    if (tbl_miss[i] > lim_remove) begin
                        gone = tbl_id[i];
                        drop_entry(i);
                        push_answer(KIND_EXPIRED, gone, ST_REMOVED, 1'b0, tbl_count, 0,
                                    1'b0);
                    end else begin
                        i++;
                    end
                end
                warn = 0;
                for (int k = 0; k < tbl_count; k++) begin
                    if (tbl_miss[k] > lim_warn) warn++;
                end
                push_answer(KIND_SUMMARY, '0, ST_REFRESHED, 1'b0, tbl_count, warn, 1'b1);
            end
            default: begin
                // unused op: no change, no result
            end
        endcase
    endfunction

    // ---------------- result checking ----------------

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            if (errors < 40)
                $display("%0t: mismatch in %s: expected %0d, actual %0d",
                         $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        answer_t a;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                errors++;
                if (errors < 40)
                    $display("%0t: unexpected result beat: expected none, actual %h/%h/%b",
                             $time, m_tuser, m_tdata, m_tlast);
            end else begin
                a = pending_answers.pop_front();
                compare_field("kind",          int'(a.kind),   int'(m_tuser));
                compare_field("module_id_res", int'(a.id),     int'(m_tdata[7:0]));
                compare_field("status",        int'(a.status), int'(m_tdata[10:8]));
                compare_field("reply_allowed", int'(a.reply),  int'(m_tdata[11]));
                compare_field("active_count",  int'(a.active), int'(m_tdata[16:12]));
                compare_field("warn_count",    int'(a.warn),   int'(m_tdata[21:17]));
                compare_field("last",          int'(a.last),   int'(m_tlast));
            end
        end
    end

    // result side back-pressure in random bursts
    initial begin
        @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    // one input beat; valid stays high after the beat for a back-to-back follower
    task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= id;
        do @(posedge aclk); while (!s_tready);
        predict_table_op(op, id);
    endtask

    // drop valid, wait for all results, then let any trailing work finish
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_limits(input logic [LIMIT_W-1:0] remove_lim,
                              input logic [LIMIT_W-1:0] warn_lim,
                              input logic [ID_W-1:0] max_id);
        settle_block();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_REMOVAL_LIMIT;
        cfg_wdata <= remove_lim;
        @(posedge aclk);
        cfg_index <= CFG_WARNING_LIMIT;
        cfg_wdata <= warn_lim;
        @(posedge aclk);
        cfg_index <= CFG_MAX_MODULE_ID;
        cfg_wdata <= max_id;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        lim_remove = remove_lim;
        lim_warn   = warn_lim;
        lim_max_id = max_id;
    endtask

    // mostly pool ids so entries get refreshed, removed and the table fills
    task automatic run_mixed(input int count);
        int              pick;
        logic [ID_W-1:0] id;
        for (int k = 0; k < POOL_SIZE; k++) id_pool[k] = ID_W'($urandom_range(0, 255));
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 85) id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            else id = ID_W'($urandom_range(0, 255));
            if (pick < 50)      send_item(OP_HEARTBEAT, id);
            else if (pick < 75) send_item(OP_TICK, ID_W'($urandom_range(0, 255)));
            else if (pick < 95) send_item(OP_REMOVE, id);
            else                send_item(OP_UNUSED, id);
        end
    endtask

    // ---------------- tests ----------------

    // add, refresh, reply bound, removes, unused op and ageing at reset limits
    task automatic test_basic_ops();
        send_item(OP_HEARTBEAT, 8'd0);
        send_item(OP_HEARTBEAT, 8'd16);
        send_item(OP_HEARTBEAT, 8'd17);
        send_item(OP_HEARTBEAT, 8'd255);
        send_item(OP_HEARTBEAT, 8'd16);
        send_item(OP_REMOVE, 8'd200);
        send_item(OP_REMOVE, 8'd17);
        send_item(OP_UNUSED, 8'hAA);
        send_item(OP_TICK, 8'h55);
        send_item(OP_TICK, 8'd0);
        send_item(OP_HEARTBEAT, 8'd0);
        send_item(OP_TICK, 8'hFF);
        send_item(OP_TICK, 8'd0);
    endtask

    // fill every slot, then a heartbeat for an absent id is refused
    task automatic test_full_table();
        for (int k = 0; k < TABLE_DEPTH; k++) send_item(OP_HEARTBEAT, 8'hE0 + ID_W'(k));
        send_item(OP_HEARTBEAT, 8'h7F);
    endtask

    // removal limit zero expires the whole full table on one tick
    task automatic test_flush_all();
        set_limits(8'd0, 8'd0, 8'd255);
        send_item(OP_TICK, 8'd0);
    endtask

    // random traffic over several limit settings, extremes included
    task automatic test_random_traffic();
        run_mixed(70);
        set_limits(8'd254, 8'd254, 8'd0);
        run_mixed(70);
        set_limits(8'd2, 8'd1, 8'd128);
        run_mixed(70);
        set_limits(LIMIT_W'($urandom_range(0, 254)), LIMIT_W'($urandom_range(0, 254)),
                   ID_W'($urandom_range(0, 255)));
        run_mixed(70);
        set_limits(8'd6, 8'd3, 8'd200);
        run_mixed(70);
    endtask

    // last part with no idling on either side
    task automatic test_calm_traffic();
        set_limits(8'd1, 8'd0, 8'd64);
        calm = 1'b1;
        run_mixed(60);
    endtask

    // reset, tests in turn, final verdict
    initial begin
        tbl_count  = 0;
        lim_remove = RESET_REMOVAL_LIMIT;
        lim_warn   = RESET_WARNING_LIMIT;
        lim_max_id = RESET_MAX_MODULE_ID;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_basic_ops();
        test_full_table();
        test_flush_all();
        test_random_traffic();
        test_calm_traffic();
        settle_block();
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: heartbeat_liveness_table_unit.f
rtl/hlt_pkg.sv
rtl/hlt_ram.sv
rtl/hlt_ctrl.sv
rtl/hlt_datapath.sv
rtl/heartbeat_liveness_table_unit.sv
sim/tb_top.sv
